/* hdl/clt_pkg.sv */
// Shared character codes, scanner modes and the types passed between the tokenizer modules.
`default_nettype none
package clt_pkg;

  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_STAR      = 8'h2a;
  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_LBRACE    = 8'h7b;
  localparam logic [7:0] CH_RBRACE    = 8'h7d;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_VTAB      = 8'h0b;
  localparam logic [7:0] CH_FORMFEED  = 8'h0c;
  localparam logic [7:0] CH_RETURN    = 8'h0d;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_LINE   = 2'd1;
  localparam logic [1:0] MODE_BLOCK  = 2'd2;
  localparam logic [1:0] MODE_QUOTE  = 2'd3;

  // Bit 8 set marks "no previous character".
  localparam logic [8:0] PREV_NONE = 9'h100;

  localparam logic [1:0] TOK_EMPTY = 2'd0;
  localparam logic [1:0] TOK_MANY  = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [8:0] prev;
    logic [1:0] tok_len;
  } scan_state_t;

  typedef struct packed {
    logic       withdraw_last;
    logic       close_token;
    logic       append_char;
    logic [7:0] char_value;
    logic       brace_token;
    logic       line_done;
    logic [1:0] scanner_mode;
  } token_mark_t;

endpackage
`default_nettype wire

/* hdl/clt_step.sv */
// Next-state and token-mark decode for one character of text.
`default_nettype none
module clt_step
  import clt_pkg::*;
(
  input  wire logic [7:0]  char_in,
  input  wire scan_state_t state,
  output scan_state_t      state_next,
  output token_mark_t      marks
);

  logic is_space;
  logic [1:0] tok_inc;

  assign is_space = (char_in == CH_SPACE) || (char_in == CH_TAB) ||
                    (char_in == CH_NEWLINE) || (char_in == CH_VTAB) ||
                    (char_in == CH_FORMFEED) || (char_in == CH_RETURN);
  assign tok_inc = (state.tok_len == TOK_MANY) ? TOK_MANY : state.tok_len + 2'd1;

  always_comb begin
    state_next = state;
    marks = '0;
    if (char_in == CH_NEWLINE) begin
      marks.close_token = 1'b1;
      marks.line_done = 1'b1;
      if (state.mode == MODE_LINE) begin
        state_next.mode = MODE_NORMAL;
      end
      state_next.prev = PREV_NONE;
      state_next.tok_len = TOK_EMPTY;
    end else begin
      case (state.mode)
        MODE_NORMAL: begin
          if (char_in == CH_HASH) begin
            marks.close_token = 1'b1;
            state_next.tok_len = TOK_EMPTY;
            state_next.mode = MODE_LINE;
          end else if (char_in == CH_STAR && state.prev == {1'b0, CH_SLASH}) begin
            // The slash went into the token unless a block comment just closed; take it back and close the rest.
            marks.withdraw_last = (state.tok_len != TOK_EMPTY);
            marks.close_token = 1'b1;
            state_next.tok_len = TOK_EMPTY;
            state_next.mode = MODE_BLOCK;
          end else if (char_in == CH_LBRACE || char_in == CH_RBRACE) begin
            marks.close_token = 1'b1;
            marks.brace_token = 1'b1;
            marks.char_value = char_in;
            marks.line_done = 1'b1;
            state_next.tok_len = TOK_EMPTY;
            state_next.prev = PREV_NONE;
          end else begin
            if (char_in == CH_QUOTE) begin
              state_next.mode = MODE_QUOTE;
            end else if (is_space) begin
              marks.close_token = 1'b1;
              state_next.tok_len = TOK_EMPTY;
            end else begin
              marks.append_char = 1'b1;
              marks.char_value = char_in;
              state_next.tok_len = tok_inc;
            end
            state_next.prev = {1'b0, char_in};
          end
        end
        MODE_LINE: begin
          state_next.prev = {1'b0, char_in};
        end
        MODE_BLOCK: begin
          if (char_in == CH_SLASH && state.prev == {1'b0, CH_STAR}) begin
            state_next.mode = MODE_NORMAL;
          end
          state_next.prev = {1'b0, char_in};
        end
        MODE_QUOTE: begin
          if (state.prev != {1'b0, CH_BACKSLASH} && char_in == CH_QUOTE) begin
            marks.close_token = 1'b1;
            state_next.tok_len = TOK_EMPTY;
            state_next.mode = MODE_NORMAL;
          end else begin
            marks.append_char = 1'b1;
            marks.char_value = char_in;
            state_next.tok_len = tok_inc;
          end
          state_next.prev = {1'b0, char_in};
        end
        default: begin
          state_next = state;
        end
      endcase
    end
    marks.scanner_mode = state_next.mode;
  end

endmodule
`default_nettype wire

/* hdl/clt_out_stage.sv */
// Result register that holds one set of token marks until the consumer takes it.
`default_nettype none
module clt_out_stage
  import clt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire token_mark_t marks,
  input  wire logic [31:0] line_in,
  input  wire logic        token_stall,
  output logic             token_valid,
  output logic             room,
  output token_mark_t      held,
  output logic [31:0]      line_held
);

  // The register can take a new result when empty or when its content leaves this cycle.
  assign room = !token_valid || !token_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (load) begin
      token_valid <= 1'b1;
    end else if (!token_stall) begin
      token_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= marks;
      line_held <= line_in;
    end
  end

endmodule
`default_nettype wire

/* hdl/comment_aware_line_tokenizer_top.sv */
// Top level of the comment-aware line tokenizer: scanner state, step decode and result register.
//
//   channel   signals                               width   direction
//   char      char_valid, char_stall, char_in        8      into the block
//   token     token_valid, token_stall, marks,      47      out of the block
//             line_number, scanner_mode
//
// One character is taken per cycle while char_stall is low; its marks appear in the result register on the next cycle.
// The scanner state updates at each char transfer, so the decode is a single short pass.
// A result waiting under token_stall holds char_stall high only while it cannot leave.
// Synchronous reset returns to normal mode, no previous character, empty token, line zero.
`default_nettype none
module comment_aware_line_tokenizer_top
  import clt_pkg::*;
#(
  parameter int LINE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        char_valid,
  output logic             char_stall,
  input  wire logic [7:0]  char_in,
  output logic             token_valid,
  input  wire logic        token_stall,
  output logic             withdraw_last,
  output logic             close_token,
  output logic             append_char,
  output logic [7:0]       char_value,
  output logic             brace_token,
  output logic             line_done,
  output logic [31:0]      line_number,
  output logic [1:0]       scanner_mode
);

  scan_state_t           state;
  scan_state_t           state_next;
  token_mark_t           marks;
  token_mark_t           held;
  logic [LINE_BITS-1:0]  line_count;
  logic [LINE_BITS-1:0]  line_count_next;
  logic [31:0]           line_out;
  logic                  room;
  logic                  accept;

  assign char_stall = !room;
  assign accept = char_valid && room;

  clt_step u_step (
    .char_in    (char_in),
    .state      (state),
    .state_next (state_next),
    .marks      (marks)
  );

  assign line_count_next = (char_in == CH_NEWLINE) ? line_count + LINE_BITS'(1) : line_count;

  generate
    if (LINE_BITS >= 32) begin : g_line_wide
      assign line_out = line_count_next[31:0];
    end else begin : g_line_narrow
      assign line_out = {{(32 - LINE_BITS){1'b0}}, line_count_next};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode <= MODE_NORMAL;
      state.prev <= PREV_NONE;
      state.tok_len <= TOK_EMPTY;
      line_count <= '0;
    end else if (accept) begin
      state <= state_next;
      line_count <= line_count_next;
    end
  end

  clt_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .marks       (marks),
    .line_in     (line_out),
    .token_stall (token_stall),
    .token_valid (token_valid),
    .room        (room),
    .held        (held),
    .line_held   (line_number)
  );

  assign withdraw_last = held.withdraw_last;
  assign close_token   = held.close_token;
  assign append_char   = held.append_char;
  assign char_value    = held.char_value;
  assign brace_token   = held.brace_token;
  assign line_done     = held.line_done;
  assign scanner_mode  = held.scanner_mode;

  a_newline_ends_line: assert property (@(posedge clk) disable iff (rst)
    accept && char_in == CH_NEWLINE |=> token_valid && line_done && close_token)
    else $error("newline transfer did not end the line");

  a_newline_counts: assert property (@(posedge clk) disable iff (rst)
    accept && char_in == CH_NEWLINE |=> line_count == $past(line_count) + LINE_BITS'(1))
    else $error("line counter did not advance on newline");

  a_withdraw_closes: assert property (@(posedge clk) disable iff (rst)
    token_valid && withdraw_last |-> close_token && scanner_mode == MODE_BLOCK)
    else $error("withdraw without block comment start");

  a_brace_line: assert property (@(posedge clk) disable iff (rst)
    token_valid && brace_token |-> line_done && close_token && scanner_mode == MODE_NORMAL)
    else $error("brace token without line end");

  a_append_xor_close: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> !(append_char && close_token))
    else $error("append and close in one result");

endmodule
`default_nettype wire

/* test/tb_comment_aware_line_tokenizer_top.sv */
// Self-checking testbench for the comment-aware line tokenizer: random and directed text.
`default_nettype none
module tb_comment_aware_line_tokenizer_top;
  import clt_pkg::*;

  localparam int ITEM_TARGET  = 950;
  localparam int IDLE_LIMIT   = 2000;
  localparam int REPORT_LIMIT = 10;
  localparam int HOLD_CYCLES  = 64;
  localparam int HOLD_AT      = 300;

  typedef struct packed {
    token_mark_t marks;
    logic [31:0] line;
  } token_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_stall;
  logic [7:0]  char_in = 8'h00;
  logic        token_valid;
  logic        token_stall = 1'b0;
  logic        withdraw_last;
  logic        close_token;
  logic        append_char;
  logic [7:0]  char_value;
  logic        brace_token;
  logic        line_done;
  logic [31:0] line_number;
  logic [1:0]  scanner_mode;

  logic [7:0]    char_queue[$];
  token_result_t pending_marks[$];

  // Scanner state as the block should hold it.
  logic [1:0]  scan_mode = MODE_NORMAL;
  logic [8:0]  scan_prev = PREV_NONE;
  logic [1:0]  tok_len = TOK_EMPTY;
  logic [31:0] line_count = '0;

  int mismatch_count = 0;
  int sent_count = 0;
  int send_gap = 0;
  int taken_count = 0;
  int take_wait = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  comment_aware_line_tokenizer_top DUT (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_in      (char_in),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .withdraw_last(withdraw_last),
    .close_token  (close_token),
    .append_char  (append_char),
    .char_value   (char_value),
    .brace_token  (brace_token),
    .line_done    (line_done),
    .line_number  (line_number),
    .scanner_mode (scanner_mode)
  );

  always #4 clk = ~clk;

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE || c == CH_VTAB ||
           c == CH_FORMFEED || c == CH_RETURN;
  endfunction

  function automatic void grow_token();
    if (tok_len != TOK_MANY) begin
      tok_len = tok_len + 2'd1;
    end
  endfunction

  // Advances the scanner by one character and returns the marks it should report.
  function automatic token_result_t scan_char(input logic [7:0] c);
    token_result_t r;
    r = '0;
    if (c == CH_NEWLINE) begin
      r.marks.close_token = 1'b1;
      r.marks.line_done = 1'b1;
      if (scan_mode == MODE_LINE) begin
        scan_mode = MODE_NORMAL;
      end
      line_count = line_count + 32'd1;
      scan_prev = PREV_NONE;
      tok_len = TOK_EMPTY;
    end else begin
      case (scan_mode)
        MODE_NORMAL: begin
          if (c == CH_HASH) begin
            r.marks.close_token = 1'b1;
            tok_len = TOK_EMPTY;
            scan_mode = MODE_LINE;
          end else if (c == CH_STAR && scan_prev == {1'b0, CH_SLASH}) begin
            // The slash went into the token unless a block comment just closed.
            r.marks.withdraw_last = (tok_len != TOK_EMPTY);
            r.marks.close_token = 1'b1;
            tok_len = TOK_EMPTY;
            scan_mode = MODE_BLOCK;
          end else if (c == CH_LBRACE || c == CH_RBRACE) begin
            r.marks.close_token = 1'b1;
            r.marks.brace_token = 1'b1;
            r.marks.char_value = c;
            r.marks.line_done = 1'b1;
            tok_len = TOK_EMPTY;
            scan_prev = PREV_NONE;
          end else begin
            if (c == CH_QUOTE) begin
              scan_mode = MODE_QUOTE;
            end else if (is_blank(c)) begin
              r.marks.close_token = 1'b1;
              tok_len = TOK_EMPTY;
            end else begin
              r.marks.append_char = 1'b1;
              r.marks.char_value = c;
              grow_token();
            end
            scan_prev = {1'b0, c};
          end
        end
        MODE_LINE: begin
          scan_prev = {1'b0, c};
        end
        MODE_BLOCK: begin
          if (c == CH_SLASH && scan_prev == {1'b0, CH_STAR}) begin
            scan_mode = MODE_NORMAL;
          end
          scan_prev = {1'b0, c};
        end
        default: begin
          if (scan_prev != {1'b0, CH_BACKSLASH} && c == CH_QUOTE) begin
            r.marks.close_token = 1'b1;
            tok_len = TOK_EMPTY;
            scan_mode = MODE_NORMAL;
          end else begin
            r.marks.append_char = 1'b1;
            r.marks.char_value = c;
            grow_token();
          end
          scan_prev = {1'b0, c};
        end
      endcase
    end
    r.line = line_count;
    r.marks.scanner_mode = scan_mode;
    return r;
  endfunction

  // Appends one character at the tail of the pending text.
  function automatic void enqueue_char(input logic [7:0] c);
    char_queue.insert(char_queue.size(), c);
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      enqueue_char(s[i]);
    end
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_VTAB;
      3: return CH_FORMFEED;
      default: return CH_RETURN;
    endcase
  endfunction

  function automatic logic [7:0] token_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(8'h61, 8'h7a));
      4: return 8'($urandom_range(8'h30, 8'h39));
      5: return 8'($urandom_range(8'h80, 8'hff));
      6: return CH_SLASH;
      7: return CH_STAR;
      8: return CH_BACKSLASH;
      default: return 8'($urandom_range(8'h21, 8'h7e));
    endcase
  endfunction

  task automatic build_text();
    int n;
    // Directed opening: extremes, every mode change and each corner of the scanner.
    enqueue_char(8'h00);
    enqueue_char(8'hff);
    push_text("a/*");
    push_text("\n");
    push_text("*/");
    push_text("*");
    push_text("*/");
    push_text("#x\n");
    push_text("\"\\\"\"");
    push_text("\"\n\"");
    push_text("{ }");
    enqueue_char(CH_TAB);
    enqueue_char(CH_VTAB);
    enqueue_char(CH_FORMFEED);
    enqueue_char(CH_RETURN);

    while (char_queue.size() < ITEM_TARGET) begin
      case ($urandom_range(0, 11))
        0, 1, 2: begin
          n = $urandom_range(1, 6);
          repeat (n) enqueue_char(token_char());
          enqueue_char($urandom_range(0, 3) == 0 ? CH_NEWLINE : blank_char());
        end
        3: enqueue_char($urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE);
        4: begin
          enqueue_char(CH_HASH);
          n = $urandom_range(0, 8);
          repeat (n) enqueue_char(8'($urandom_range(0, 255)));
          enqueue_char(CH_NEWLINE);
        end
        5, 6: begin
          n = $urandom_range(0, 3);
          repeat (n) enqueue_char(token_char());
          push_text("/*");
          n = $urandom_range(0, 8);
          repeat (n) begin
            enqueue_char($urandom_range(0, 3) == 0 ? CH_STAR : token_char());
          end
          push_text("*/");
        end
        7, 8: begin
          enqueue_char(CH_QUOTE);
          n = $urandom_range(0, 8);
          repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
              enqueue_char(CH_BACKSLASH);
              enqueue_char(CH_QUOTE);
            end else begin
              enqueue_char($urandom_range(0, 5) == 0 ? blank_char() : token_char());
            end
          end
          enqueue_char(CH_QUOTE);
        end
        9: enqueue_char(CH_NEWLINE);
        10: begin
          n = $urandom_range(1, 4);
          repeat (n) enqueue_char(8'($urandom_range(0, 255)));
        end
        default: begin
          n = $urandom_range(1, 3);
          repeat (n) enqueue_char(blank_char());
        end
      endcase
    end
  endtask

  // Sender: each transfer is followed by a random gap, except in the calm stretches.
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      char_valid <= 1'b0;
      send_gap <= 0;
    end else if (char_valid && !char_stall) begin
      sent_count = sent_count + 1;
      gap = (sent_count[7:6] == 2'b01) ? 0 : $urandom_range(0, 5);
      if (gap == 0 && char_queue.size() != 0) begin
        char_in <= char_queue.pop_front();
      end else begin
        char_valid <= 1'b0;
        send_gap <= gap;
      end
    end else if (!char_valid) begin
      if (send_gap > 1) begin
        send_gap <= send_gap - 1;
      end else if (char_queue.size() != 0) begin
        char_valid <= 1'b1;
        char_in <= char_queue.pop_front();
        send_gap <= 0;
      end
    end
  end

  // Receiver: random stall after each transfer, and one long hold-off to back up the input.
  always @(posedge clk) begin
    if (rst) begin
      token_stall <= 1'b0;
    end else begin
      if (token_valid && !token_stall) begin
        taken_count = taken_count + 1;
        take_wait = (taken_count[7:6] == 2'b01) ? 0 : $urandom_range(0, 5);
        if (taken_count == HOLD_AT) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        token_stall <= 1'b1;
      end else if (take_wait > 0) begin
        take_wait = take_wait - 1;
        token_stall <= 1'b1;
      end else begin
        token_stall <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each char transfer, then checks each token transfer in order.
  always @(posedge clk) begin
    token_result_t got;
    token_result_t want;
    if (!rst) begin
      if (char_valid && !char_stall) begin
        want = scan_char(char_in);
        pending_marks.insert(pending_marks.size(), want);
      end
      if (token_valid && !token_stall) begin
        got.marks.withdraw_last = withdraw_last;
        got.marks.close_token = close_token;
        got.marks.append_char = append_char;
        got.marks.char_value = char_value;
        got.marks.brace_token = brace_token;
        got.marks.line_done = line_done;
        got.marks.scanner_mode = scanner_mode;
        got.line = line_number;
        if (pending_marks.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("Unexpected token transfer with nothing pending");
          end
        end else begin
          want = pending_marks.pop_front();
          if (got !== want) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("Mismatch: expected wd=%b cl=%b ap=%b cv=%h br=%b ld=%b line=%0d mode=%0d",
                       want.marks.withdraw_last, want.marks.close_token,
                       want.marks.append_char, want.marks.char_value,
                       want.marks.brace_token, want.marks.line_done, want.line,
                       want.marks.scanner_mode);
              $display("          actual   wd=%b cl=%b ap=%b cv=%h br=%b ld=%b line=%0d mode=%0d",
                       got.marks.withdraw_last, got.marks.close_token,
                       got.marks.append_char, got.marks.char_value,
                       got.marks.brace_token, got.marks.line_done, got.line,
                       got.marks.scanner_mode);
            end
          end
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (token_valid && !token_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    build_text();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (char_queue.size() != 0 || char_valid || pending_marks.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_marks.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
